>>> rtl/itp_pkg.sv
// itp_pkg: types, character codes and digit decode shared by the parser files.
// No dependencies.
package itp_pkg;

    typedef enum logic [2:0] {
        PH_START,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        RADIX_DEC,
        RADIX_OCT,
        RADIX_HEX
    } radix_t;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LX    = 8'h78;
    localparam logic [7:0] CHAR_UX    = 8'h58;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF    = 8'h66;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;

    localparam int unsigned ACC_W = 32;

    typedef struct packed {
        phase_t             phase;
        radix_t             radix;
        logic [ACC_W-1:0]   acc;
        logic               neg;
    } parse_state_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } digit_t;

    // Digit value of a byte in the given radix; valid clear when it is not a digit.
    function automatic digit_t digit_of(logic [7:0] c, radix_t rc);
        digit_t d;
        logic [7:0] off;
        d.valid = 1'b0;
        d.value = 4'd0;
        off = 8'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            off = c - CHAR_ZERO;
            d.valid = 1'b1;
            d.value = off[3:0];
        end else if (c >= CHAR_LA && c <= CHAR_LF) begin
            off = c - CHAR_LA + 8'd10;
            d.valid = 1'b1;
            d.value = off[3:0];
        end else if (c >= CHAR_UA && c <= CHAR_UF) begin
            off = c - CHAR_UA + 8'd10;
            d.valid = 1'b1;
            d.value = off[3:0];
        end
        case (rc)
            RADIX_OCT: if (d.value >= 4'd8) d.valid = 1'b0;
            RADIX_HEX: ;
            default:   if (d.value >= 4'd10) d.valid = 1'b0;
        endcase
        return d;
    endfunction

endpackage

>>> rtl/integer_text_parser_auto_base_unit.sv
// A word accepted goes to the input register; with last_char set, its result then
// moves to the result register (out_valid high) when that word advances.
// Throughput: one word per cycle; a last word waits, stalling the input, only while
// the result register is full and out_stall is high.
// Reset (rst_n low, async): parser back to start of string, decimal, zero
// accumulator, no sign; input and result registers empty. Uses itp_pkg, itp_step.
module integer_text_parser_auto_base_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         char_code,
    input  logic               last_char,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] parsed_value
);

    logic                  in_valid_reg;
    logic [7:0]            char_reg;
    logic                  last_reg;
    itp_pkg::parse_state_t state_reg;
    itp_pkg::parse_state_t state_next;
    itp_pkg::parse_state_t step_out;
    logic                  out_valid_reg;
    logic [31:0]           out_value_reg;
    logic [31:0]           step_value;
    logic                  advance;
    logic                  accept_in;

    itp_step u_step
    (
        .cur       (state_reg),
        .char_code (char_reg),
        .nxt       (step_out),
        .value     (step_value)
    );

    // a last word waits only while the result register is full and stalled
    assign advance   = in_valid_reg && (!last_reg || !out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign accept_in = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        if (advance)
        begin
            if (last_reg)
            begin
                state_next.phase = itp_pkg::PH_START;
                state_next.radix = itp_pkg::RADIX_DEC;
                state_next.acc   = '0;
                state_next.neg   = 1'b0;
            end
            else
            begin
                state_next = step_out;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg.phase <= itp_pkg::PH_START;
            state_reg.radix <= itp_pkg::RADIX_DEC;
            state_reg.acc   <= '0;
            state_reg.neg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept_in)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance && last_reg)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            char_reg <= char_code;
            last_reg <= last_char;
        end
        if (advance && last_reg)
            out_value_reg <= step_value;
    end

    assign out_valid    = out_valid_reg;
    assign parsed_value = $signed(out_value_reg);

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && last_reg) |=> (state_reg.phase == itp_pkg::PH_START && state_reg.acc == '0))
        else $error("parser state not cleared after last word");

    a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == itp_pkg::PH_START)
            |-> (state_reg.acc == '0 && !state_reg.neg && state_reg.radix == itp_pkg::RADIX_DEC))
        else $error("start phase with dirty state");

    a_signed_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == itp_pkg::PH_SIGNED) |-> (state_reg.neg && state_reg.acc == '0))
        else $error("sign phase without sign or with digits");

    a_zero_octal: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == itp_pkg::PH_ZERO)
            |-> (state_reg.radix == itp_pkg::RADIX_OCT && state_reg.acc == '0))
        else $error("leading zero phase not octal");

    a_result_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid_reg)) |-> $past(advance && last_reg))
        else $error("result raised without a last word");

endmodule

>>> rtl/itp_step.sv
// itp_step: next parse state for one character (prefix decode, digit accumulate)
// and the signed value that state yields. Depends on itp_pkg.
module itp_step
(
    input  itp_pkg::parse_state_t  cur,
    input  logic [7:0]             char_code,
    output itp_pkg::parse_state_t  nxt,
    output logic [31:0]            value
);

    itp_pkg::digit_t dig;
    itp_pkg::phase_t phase_next;
    logic is_minus;
    logic is_zero;
    logic is_x;
    logic sign_hit;
    logic zero_hit;
    logic hex_hit;
    logic take;
    logic [31:0] scaled;

    assign dig      = itp_pkg::digit_of(char_code, cur.radix);
    assign is_minus = (char_code == itp_pkg::CHAR_MINUS);
    assign is_zero  = (char_code == itp_pkg::CHAR_ZERO);
    assign is_x     = (char_code == itp_pkg::CHAR_LX) || (char_code == itp_pkg::CHAR_UX);

    always_comb
    begin
        sign_hit = 1'b0;
        zero_hit = 1'b0;
        hex_hit  = 1'b0;
        take     = 1'b0;
        unique case (cur.phase)
            itp_pkg::PH_START:
            begin
                sign_hit = is_minus;
                zero_hit = !is_minus && is_zero;
                take     = !is_minus && !is_zero;
            end
            itp_pkg::PH_SIGNED:
            begin
                zero_hit = is_zero;
                take     = !is_zero;
            end
            itp_pkg::PH_ZERO:
            begin
                hex_hit = is_x;
                take    = !is_x;
            end
            itp_pkg::PH_DIGITS: take = 1'b1;
            default:            ;
        endcase
    end

    // next phase
    always_comb
    begin
        if (sign_hit)
            phase_next = itp_pkg::PH_SIGNED;
        else if (zero_hit)
            phase_next = itp_pkg::PH_ZERO;
        else if (hex_hit)
            phase_next = itp_pkg::PH_DIGITS;
        else if (take)
            phase_next = dig.valid ? itp_pkg::PH_DIGITS : itp_pkg::PH_DONE;
        else
            phase_next = itp_pkg::PH_DONE;
    end

    always_comb
    begin
        case (cur.radix)
            itp_pkg::RADIX_OCT: scaled = {cur.acc[28:0], 3'b000};
            itp_pkg::RADIX_HEX: scaled = {cur.acc[27:0], 4'b0000};
            default:            scaled = {cur.acc[28:0], 3'b000} + {cur.acc[30:0], 1'b0};
        endcase
    end

    // data updates
    always_comb
    begin
        nxt.phase = phase_next;
        nxt.neg   = cur.neg | sign_hit;
        nxt.radix = cur.radix;
        nxt.acc   = cur.acc;
        if (zero_hit)
            nxt.radix = itp_pkg::RADIX_OCT;
        if (hex_hit)
            nxt.radix = itp_pkg::RADIX_HEX;
        if (take && dig.valid)
            nxt.acc = scaled + {28'd0, dig.value};
    end

    assign value = nxt.neg ? (32'd0 - nxt.acc) : nxt.acc;

endmodule

>>> dv/parsed_value_checker.sv
// parsed_value_checker: watches both channels of the text parser, predicts each
// parsed value from the accepted characters and compares it in order.
// Depends on itp_pkg for the phase/radix enums and character codes.
module parsed_value_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [7:0]         char_code,
    input  logic               last_char,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] parsed_value,
    output int                 fail_count,
    output int                 pending,
    output int                 checked
);

    localparam int unsigned NOT_A_DIGIT = 16;

    itp_pkg::phase_t phase;
    itp_pkg::radix_t radix;
    logic [31:0]     acc;
    logic            neg;
    logic [31:0]     pending_values[$];

    // Digit weight of c in radix r, NOT_A_DIGIT when it does not belong.
    function automatic int unsigned weight_in_radix(logic [7:0] c, itp_pkg::radix_t r);
        int unsigned w;
        int unsigned limit;
        w = NOT_A_DIGIT;
        if (c inside {[itp_pkg::CHAR_ZERO:itp_pkg::CHAR_NINE]})
            w = int'(c) - int'(itp_pkg::CHAR_ZERO);
        else if (c inside {[itp_pkg::CHAR_LA:itp_pkg::CHAR_LF]})
            w = int'(c) - int'(itp_pkg::CHAR_LA) + 10;
        else if (c inside {[itp_pkg::CHAR_UA:itp_pkg::CHAR_UF]})
            w = int'(c) - int'(itp_pkg::CHAR_UA) + 10;
        case (r)
            itp_pkg::RADIX_OCT: limit = 8;
            itp_pkg::RADIX_HEX: limit = 16;
            default:            limit = 10;
        endcase
        return (w < limit) ? w : NOT_A_DIGIT;
    endfunction

    task automatic advance_parse(input logic [7:0] c, input logic is_last);
        int unsigned w;
        int unsigned radix_base;
        logic [31:0] value;
        if (phase == itp_pkg::PH_START && c == itp_pkg::CHAR_MINUS) begin
            neg   = 1'b1;
            phase = itp_pkg::PH_SIGNED;
        end else if ((phase == itp_pkg::PH_START || phase == itp_pkg::PH_SIGNED)
                     && c == itp_pkg::CHAR_ZERO) begin
            radix = itp_pkg::RADIX_OCT;
            phase = itp_pkg::PH_ZERO;
        end else if (phase == itp_pkg::PH_ZERO
                     && (c == itp_pkg::CHAR_LX || c == itp_pkg::CHAR_UX)) begin
            radix = itp_pkg::RADIX_HEX;
            phase = itp_pkg::PH_DIGITS;
        end else if (phase != itp_pkg::PH_DONE) begin
            w = weight_in_radix(c, radix);
            radix_base = (radix == itp_pkg::RADIX_HEX) ? 16 :
                         (radix == itp_pkg::RADIX_OCT) ? 8 : 10;
            if (w == NOT_A_DIGIT) begin
                phase = itp_pkg::PH_DONE;
            end else begin
                acc   = acc * radix_base + w;
                phase = itp_pkg::PH_DIGITS;
            end
        end
        if (is_last) begin
            value = neg ? (32'd0 - acc) : acc;
            pending_values.push_back(value);
            phase = itp_pkg::PH_START;
            radix = itp_pkg::RADIX_DEC;
            acc   = '0;
            neg   = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [31:0] want;
        if (!rst_n) begin
            phase = itp_pkg::PH_START;
            radix = itp_pkg::RADIX_DEC;
            acc   = '0;
            neg   = 1'b0;
            pending_values.delete();
            fail_count = 0;
            checked    = 0;
        end else begin
            // a result word leaves only after its last character has passed the input and
            // result registers, so the compare goes ahead of this edge's prediction
            if (out_valid && !out_stall) begin
                if (pending_values.size() == 0) begin
                    $display("%0t: unexpected parsed_value %0d (0x%08h), none expected",
                             $time, parsed_value, parsed_value);
                    fail_count++;
                end else begin
                    want = pending_values.pop_front();
                    checked++;
                    if (parsed_value !== want) begin
                        $display("%0t: parsed_value expected %0d (0x%08h), actual %0d (0x%08h)",
                                 $time, $signed(want), want, parsed_value, parsed_value);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                advance_parse(char_code, last_char);
        end
        pending = pending_values.size();
    end

endmodule

>>> dv/testbench.sv
// testbench: top of the parser regression; drives character strings, idles both
// channels and gives the verdict. Depends on itp_pkg, the parser top and
// parsed_value_checker.
module testbench;

    typedef logic [7:0] char_q_t[$];

    localparam int TOTAL_CHARS    = 1650;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 1000;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic [7:0]         char_code  = 8'h00;
    logic               last_char  = 1'b0;
    logic               out_stall  = 1'b0;
    logic               in_stall;
    logic               out_valid;
    logic signed [31:0] parsed_value;

    int fail_count;
    int pending;
    int checked;
    int send_idle   = 0;
    int recv_idle   = 0;
    int chars_sent  = 0;
    int strings_sent = 0;
    int quiet_cycles = 0;
    bit hold_req    = 1'b0;

    always #5 clk = ~clk;

    integer_text_parser_auto_base_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_code    (char_code),
        .last_char    (last_char),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .parsed_value (parsed_value)
    );

    parsed_value_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_code    (char_code),
        .last_char    (last_char),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .parsed_value (parsed_value),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked)
    );

    function automatic char_q_t chars_of(string s);
        char_q_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    function automatic logic [7:0] digit_char(int unsigned v);
        if (v < 10)
            return itp_pkg::CHAR_ZERO + 8'(v);
        return ($urandom_range(1) ? itp_pkg::CHAR_LA : itp_pkg::CHAR_UA) + 8'(v - 10);
    endfunction

    // Mostly well-formed numbers (sign, prefix, digits of the base); some get a
    // stray byte spliced in, the rest is raw noise.
    function automatic char_q_t random_number_text();
        char_q_t q;
        int unsigned kind;
        itp_pkg::radix_t radix_sel;
        int unsigned ndigits;
        kind = $urandom_range(99);
        if (kind < 15) begin
            repeat ($urandom_range(6, 1))
                q.push_back(8'($urandom_range(255)));
            return q;
        end
        if ($urandom_range(1))
            q.push_back(itp_pkg::CHAR_MINUS);
        radix_sel = itp_pkg::radix_t'(2'($urandom_range(2)));
        if (radix_sel != itp_pkg::RADIX_DEC)
            q.push_back(itp_pkg::CHAR_ZERO);
        if (radix_sel == itp_pkg::RADIX_HEX)
            q.push_back($urandom_range(1) ? itp_pkg::CHAR_LX : itp_pkg::CHAR_UX);
        ndigits = ($urandom_range(9) == 0) ? $urandom_range(14, 9) : $urandom_range(8);
        repeat (ndigits) begin
            case (radix_sel)
                itp_pkg::RADIX_DEC: q.push_back(digit_char($urandom_range(9)));
                itp_pkg::RADIX_OCT: q.push_back(digit_char($urandom_range(7)));
                default:            q.push_back(digit_char($urandom_range(15)));
            endcase
        end
        if (q.size() == 0)
            q.push_back(digit_char($urandom_range(9)));
        if (kind < 35)
            q.insert($urandom_range(q.size()), 8'($urandom_range(255)));
        return q;
    endfunction

    task automatic send_text(input char_q_t s);
        for (int i = 0; i < s.size(); i++) begin
            while ($urandom_range(99) < send_idle) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid  <= 1'b1;
            char_code <= s[i];
            last_char <= (i == s.size() - 1);
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            chars_sent++;
        end
        strings_sent++;
    endtask

    // receiver side: random stall, or a long hold when requested
    initial
    begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                out_stall <= ($urandom_range(99) < recv_idle);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d values still due",
                     $time, quiet_cycles, pending);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        char_q_t one_digit;
        char_q_t mixed;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty numbers, lone zeros, a minus after a digit, both prefixes,
        // octal cut short, a zero byte mid-string and the top byte code
        send_idle = 0;
        recv_idle = 0;
        send_text(chars_of("-"));
        send_text(chars_of("x"));
        send_text(chars_of("-0x"));
        send_text(chars_of("0"));
        send_text(chars_of("-0"));
        send_text(chars_of("1-2"));
        send_text(chars_of("0XaF"));
        send_text(chars_of("09"));
        mixed = chars_of("7");
        mixed.push_back(8'h00);
        mixed.push_back(8'h33);
        send_text(mixed);
        mixed.delete();
        mixed.push_back(8'hFF);
        send_text(mixed);

        send_idle = 10;
        recv_idle = 69;
        while (chars_sent < TOTAL_CHARS / 3)
            send_text(random_number_text());

        send_idle = 69;
        recv_idle = 10;
        while (chars_sent < 2 * TOTAL_CHARS / 3)
            send_text(random_number_text());

        // back-to-back single-digit strings against a held output fill the pipe
        send_idle = 0;
        recv_idle = 0;
        hold_req  = 1'b1;
        repeat (12) begin
            one_digit.delete();
            one_digit.push_back(digit_char($urandom_range(9)));
            send_text(one_digit);
        end
        while (chars_sent < TOTAL_CHARS)
            send_text(random_number_text());
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Run covered %0d characters in %0d strings, %0d parsed values compared",
                 chars_sent, strings_sent, checked);
        $display("idle mixes 10/69, 69/10 and none, plus a %0d-cycle output hold",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
